FILE: rtl/bdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_pkg - shared types and constants of the byte addressed data memory
// access kinds, bank count, data segment base and the decode control group
// ----------------------------------------------------------------------------
package bdm_pkg;

	localparam int NBANKS = 4;
	localparam logic [31:0] DATA_BASE = 32'h1001_0000;

	typedef enum logic [2:0] {
		KIND_RD_B = 3'd0,
		KIND_RD_H = 3'd1,
		KIND_RD_W = 3'd2,
		KIND_WR_B = 3'd3,
		KIND_WR_H = 3'd4,
		KIND_WR_W = 3'd5
	} kind_t;

	// decode result for one access
	typedef struct packed {
		logic              err;       // some byte of the access is out of bounds
		logic              wr;        // a write kind
		logic [1:0]        lo;        // bank of the first byte
		logic [1:0]        nm1;       // byte count minus one
		logic [NBANKS-1:0] row_inc;   // bank reads the row after the first one
		logic [NBANKS-1:0] wr_en;     // per bank write strobe
	} dec_ctl_t;

	// map a byte address to a store offset
	function automatic logic [31:0] map_off(input logic [31:0] a);
		return (a >= DATA_BASE) ? (a - DATA_BASE) : a;
	endfunction

endpackage

FILE: rtl/bdm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_ram - generic single port ram
// one read or write per cycle, registered read data, no reset on contents
// ----------------------------------------------------------------------------
module bdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/bdm_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_decode - access decode
// maps first and last byte addresses, checks bounds, builds bank strobes
// ----------------------------------------------------------------------------
module bdm_decode #(
	parameter int MEM_BYTES = 4096,
	localparam int ROWS = (MEM_BYTES + 3) / 4,
	localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic [2:0]             kind,
	input  logic [31:0]            address,
	input  logic [31:0]            write_data,
	output bdm_pkg::dec_ctl_t      ctl,
	output logic [AW-1:0]          row0,
	output logic [3:0][7:0]        wr_bytes
);
	import bdm_pkg::*;

	localparam logic [31:0] LIMIT = 32'(MEM_BYTES);

	logic        kind_ok;
	logic        is_wr;
	logic [1:0]  nm1;
	logic [31:0] last_addr;
	logic [31:0] off0;
	logic [31:0] off_last;
	logic        err;
	logic [1:0]  idx [NBANKS];
	logic [31:0] shifted [NBANKS];

	always_comb begin
		kind_ok = 1'b1;
		is_wr   = 1'b0;
		nm1     = 2'd0;
		case (kind_t'(kind))
			KIND_RD_B: nm1 = 2'd0;
			KIND_RD_H: nm1 = 2'd1;
			KIND_RD_W: nm1 = 2'd3;
			KIND_WR_B: begin
				nm1   = 2'd0;
				is_wr = 1'b1;
			end
			KIND_WR_H: begin
				nm1   = 2'd1;
				is_wr = 1'b1;
			end
			KIND_WR_W: begin
				nm1   = 2'd3;
				is_wr = 1'b1;
			end
			default: kind_ok = 1'b0;
		endcase
	end

	// a span that is in bounds at both ends is contiguous in the store
	assign last_addr = address + {30'd0, nm1};
	assign off0      = map_off(address);
	assign off_last  = map_off(last_addr);
	assign err       = kind_ok && ((off0 >= LIMIT) || (off_last >= LIMIT));
	assign row0      = off0[AW+1:2];

	always_comb begin
		ctl.err = err;
		ctl.wr  = is_wr;
		ctl.lo  = off0[1:0];
		ctl.nm1 = nm1;
		for (int b = 0; b < NBANKS; b++) begin
			idx[b]         = 2'(b) - off0[1:0];
			ctl.row_inc[b] = 2'(b) < off0[1:0];
			ctl.wr_en[b]   = kind_ok && is_wr && !err && (idx[b] <= nm1);
			shifted[b]     = write_data >> {idx[b], 3'b000};
			wr_bytes[b]    = shifted[b][7:0];
		end
	end

endmodule

FILE: rtl/bdm_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_align - read word assembly
// rotates bank bytes into order and sign extends narrow reads
// ----------------------------------------------------------------------------
module bdm_align (
	input  bdm_pkg::kind_t        kind,
	input  logic [1:0]            lo,
	input  logic                  err,
	input  logic [3:0][7:0]       bank_data,
	output logic signed [31:0]    value
);
	import bdm_pkg::*;

	logic [63:0] dbl;
	logic [63:0] rot;
	logic [31:0] word;

	assign dbl  = {bank_data, bank_data};
	assign rot  = dbl >> {lo, 3'b000};
	assign word = rot[31:0];

	always_comb begin
		value = '0;
		if (!err) begin
			case (kind)
				KIND_RD_B: value = {{24{word[7]}}, word[7:0]};
				KIND_RD_H: value = {{16{word[15]}}, word[15:0]};
				KIND_RD_W: value = word;
				default:   value = '0;
			endcase
		end
	end

endmodule

FILE: rtl/byte_addressed_data_memory.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_addressed_data_memory - little endian data memory with byte banks
// byte, half and word reads and writes at any alignment, bounds checked
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid, in_stall   | kind, address, write_data
//  out     | out_valid, out_stall | read_data, range_err
//
//  one word accepted per cycle while in_stall is low; its result passes the
//  bank read register, then the result register, before it is offered
//  after reset the four banks are swept to zero, one row a cycle, through
//  all ceil(MEM_BYTES/4) rows, with in_stall held high
//  a stall on the output holds the result register and the bank read stage,
//  and outside the zero sweep in_stall rises only when both are full
// ----------------------------------------------------------------------------
module byte_addressed_data_memory #(
	parameter int MEM_BYTES = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         kind,
	input  logic [31:0]        address,
	input  logic [31:0]        write_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_data,
	output logic               range_err
);
	import bdm_pkg::*;

	localparam int ROWS = (MEM_BYTES + 3) / 4;
	localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	// handshake
	logic in_accept;
	logic out_free;
	logic s1_move;

	// clearing sweep
	logic          clearing_q;
	logic [AW-1:0] clr_q;

	// decode of the word at the input
	dec_ctl_t       ctl;
	logic [AW-1:0]  row0;
	logic [3:0][7:0] wr_bytes;

	// banks
	logic [3:0][7:0] bank_rd;

	// stage 1: bank read data plus what is needed to assemble it
	logic       s1_valid_q;
	kind_t      kind_s1;
	logic [1:0] lo_s1;
	logic       err_s1;

	logic signed [31:0] value;

	// output register
	logic               out_valid_q;
	logic signed [31:0] read_data_q;
	logic               range_err_q;

	// the output register frees when empty or taken this cycle
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_move   = s1_valid_q && out_free;
	assign in_stall  = clearing_q || (s1_valid_q && !out_free);
	assign in_accept = in_valid && !in_stall;

	bdm_decode #(
		.MEM_BYTES(MEM_BYTES)
	) u_decode (
		.kind      (kind),
		.address   (address),
		.write_data(write_data),
		.ctl       (ctl),
		.row0      (row0),
		.wr_bytes  (wr_bytes)
	);

	// four byte banks; bank b holds the offsets whose low two bits equal b
	for (genvar b = 0; b < NBANKS; b++) begin : g_bank
		logic          b_we;
		logic [AW-1:0] b_addr;
		logic [7:0]    b_wdata;

		assign b_we    = clearing_q || (in_accept && ctl.wr_en[b]);
		assign b_addr  = clearing_q ? clr_q : (row0 + AW'(ctl.row_inc[b]));
		assign b_wdata = clearing_q ? 8'h00 : wr_bytes[b];

		bdm_ram #(
			.WIDTH(8),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.en   (in_accept),
			.we   (b_we),
			.addr (b_addr),
			.wdata(b_wdata),
			.rdata(bank_rd[b])
		);
	end

	// zero sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == AW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	// payload follows the bank read enable so it stays lined up while held
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= kind_t'(kind);
			lo_s1   <= ctl.lo;
			err_s1  <= ctl.err;
		end
	end

	bdm_align u_align (
		.kind     (kind_s1),
		.lo       (lo_s1),
		.err      (err_s1),
		.bank_data(bank_rd),
		.value    (value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			read_data_q <= value;
			range_err_q <= err_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign range_err = range_err_q;

	// a rejected write must leave every bank untouched
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.err |-> (ctl.wr_en == '0))
		else $error("out of bounds access drives a bank write");

	// a good write strobes exactly as many banks as it has bytes
	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && ctl.wr && !ctl.err) |->
		($countones(ctl.wr_en) == (int'(ctl.nm1) + 1)))
		else $error("write strobe count does not match access size");

	// a held bank read stage is never overwritten
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free) |-> !in_accept)
		else $error("new word accepted over a held bank read");

	// an error result carries zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && range_err_q) |-> (read_data_q == '0))
		else $error("out of bounds result with non zero data");

	// nothing is taken in during the zero sweep
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s1_valid_q)
		else $error("word in flight during zero sweep");

endmodule
